@@ design/pse_pkg.sv @@
// shared types, constants and lookup functions for the segment extruder
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam logic [15:0] TEX_LO  = 16'd5243;
  localparam logic [15:0] TEX_HI  = 16'd60293;
  localparam logic [15:0] TEX_MID = 16'd32768;
  localparam logic [15:0] BASE_STEP = 16'd8;
  localparam logic KIND_VERTEX   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  // one segment handed from the front to the back
  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] bz;
    logic [15:0] base;
  } pse_seg_t;

  typedef struct packed {
    logic     valid;
    pse_seg_t seg;
  } pse_push_t;

  typedef struct packed {
    logic full;
    logic valid;
  } pse_qstat_t;

  function automatic logic [15:0] tex_u_of(input logic [2:0] k);
    logic [15:0] r;
    case (k)
      3'd0, 3'd1: r = TEX_LO;
      3'd6, 3'd7: r = TEX_HI;
      default:    r = TEX_MID;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] tex_v_of(input logic [2:0] k);
    return k[0] ? TEX_HI : TEX_LO;
  endfunction

  // corners of the six triangles: (0,2,1) (2,3,1) (2,4,3) (4,5,3) (4,6,5) (6,7,5)
  function automatic logic [2:0] tri_corner(input logic [2:0] t, input logic [1:0] c);
    logic [2:0] r;
    logic [2:0] lo;
    lo = {t[2:1], 1'b0};
    case (c)
      2'd0:    r = t[0] ? lo + 3'd2 : lo;
      2'd1:    r = t[0] ? lo + 3'd3 : lo + 3'd2;
      default: r = lo + 3'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/pse_if.sv @@
// stream interfaces for points in and records out
`timescale 1ns / 1ps
`default_nettype none
interface pse_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               path_start;
  modport source (output valid, point_x, point_y, point_z, path_start, input ready);
  modport sink (input valid, point_x, point_y, point_z, path_start, output ready);
endinterface

interface pse_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [15:0]        tex_u;
  logic [15:0]        tex_v;
  logic [15:0]        vertex_number;
  logic [15:0]        corner_a;
  logic [15:0]        corner_b;
  logic [15:0]        corner_c;
  logic               last;
  modport source (output valid, kind, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_number,
                  corner_a, corner_b, corner_c, last, input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_number,
                corner_a, corner_b, corner_c, last, output ready);
endinterface
`default_nettype wire

@@ design/pse_front.sv @@
// front: takes points, keeps the previous point and queues segments
`timescale 1ns / 1ps
`default_nettype none
module pse_front
  import pse_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  pse_in_if.sink     in_ch,
  input  pse_qstat_t qstat,
  output pse_push_t  push
);

  logic [31:0] prev_x_r, prev_y_r, prev_z_r;
  logic [31:0] prev_x_nxt, prev_y_nxt, prev_z_nxt;
  logic        have_prev_r, have_prev_nxt;
  logic [15:0] base_r, base_nxt;
  logic        beat;
  logic        is_seg;

  assign in_ch.ready = !qstat.full;
  assign beat        = in_ch.valid && in_ch.ready;
  assign is_seg      = !in_ch.path_start && have_prev_r;

  assign push.valid    = beat && is_seg;
  assign push.seg.ax   = prev_x_r;
  assign push.seg.ay   = prev_y_r;
  assign push.seg.az   = prev_z_r;
  assign push.seg.bx   = in_ch.point_x;
  assign push.seg.by   = in_ch.point_y;
  assign push.seg.bz   = in_ch.point_z;
  assign push.seg.base = base_r;

  always_comb begin
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    prev_z_nxt    = prev_z_r;
    have_prev_nxt = have_prev_r;
    base_nxt      = base_r;
    if (beat) begin
      prev_x_nxt    = in_ch.point_x;
      prev_y_nxt    = in_ch.point_y;
      prev_z_nxt    = in_ch.point_z;
      have_prev_nxt = 1'b1;
      if (in_ch.path_start) begin
        base_nxt = '0;
      end else if (is_seg) begin
        base_nxt = base_r + BASE_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
      have_prev_r <= 1'b0;
      base_r      <= '0;
    end else begin
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      prev_z_r    <= prev_z_nxt;
      have_prev_r <= have_prev_nxt;
      base_r      <= base_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/pse_queue.sv @@
// short segment queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module pse_queue
  import pse_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  pse_push_t  push,
  input  wire logic  pop,
  output pse_qstat_t qstat,
  output pse_seg_t   head
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  pse_seg_t        ent_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     count_r;

  assign qstat.full  = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign qstat.valid = (count_r != '0);
  assign head        = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      ent_r[wr_ptr_r] <= push.seg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (PW+1)'(push.valid) - (PW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

@@ design/pse_back.sv @@
// back: direction, root, divides, then the fourteen output records
`timescale 1ns / 1ps
`default_nettype none
module pse_back
  import pse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  pse_qstat_t       qstat,
  input  pse_seg_t         head,
  input  wire logic [30:0] half_width,
  output logic             pop,
  pse_out_if.source        out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_ABS, S_MAX, S_NORM, S_SQ, S_ROOT, S_MUL, S_DIV0, S_DIV, S_EMIT
  } state_t;

  state_t       state_r;
  pse_seg_t     seg_r;
  logic         neg_r [3];
  logic [32:0]  m_r [3];
  logic [32:0]  mx_r;
  logic [61:0]  sum_r;
  logic [63:0]  v_r, res_r, bit_r;
  logic [31:0]  len_r;
  logic [61:0]  prod_r;
  logic [31:0]  rem_r, lo_r, quo_r;
  logic [5:0]   step_r;
  logic [1:0]   idx_r;
  logic [31:0]  e_r [3];
  logic [3:0]   k_r;

  logic         out_valid_r, out_kind_r, out_last_r;
  logic [31:0]  out_px_r, out_py_r, out_pz_r;
  logic [15:0]  out_tu_r, out_tv_r, out_vn_r, out_ca_r, out_cb_r, out_cc_r;

  logic [63:0]  rb;
  logic [32:0]  trial;
  logic [63:0]  num;
  logic [31:0]  ex, ey, ez, ox, oy, oz, bpx, bpy, bpz;
  logic [2:0]   tk;
  logic         slot_free;

  assign pop = (state_r == S_IDLE) && qstat.valid;
  assign rb    = res_r + bit_r;
  assign trial = {rem_r, lo_r[31]};
  assign num   = {2'b0, prod_r} + {33'b0, len_r[31:1]};
  assign ex = e_r[0];
  assign ey = e_r[1];
  assign ez = e_r[2];
  assign tk = k_r[2:0] - 3'd0;
  assign slot_free = !out_valid_r || out_ch.ready;

  // side offsets per vertex, with N = (-ey, ex, 0)
  always_comb begin
    case (tk)
      3'd0:       begin ox = ey - ex;      oy = 32'd0 - ex - ey; oz = 32'd0 - ez; end
      3'd1:       begin ox = 32'd0 - ey - ex; oy = ex - ey;      oz = 32'd0 - ez; end
      3'd2, 3'd4: begin ox = ey;           oy = 32'd0 - ex;      oz = '0; end
      3'd3, 3'd5: begin ox = 32'd0 - ey;   oy = ex;              oz = '0; end
      3'd6:       begin ox = ey + ex;      oy = ey - ex;         oz = ez; end
      default:    begin ox = ex - ey;      oy = ex + ey;         oz = ez; end
    endcase
    bpx = k_r[2] ? seg_r.bx : seg_r.ax;
    bpy = k_r[2] ? seg_r.by : seg_r.ay;
    bpz = k_r[2] ? seg_r.bz : seg_r.az;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_kind_r;
  assign out_ch.pos_x         = out_px_r;
  assign out_ch.pos_y         = out_py_r;
  assign out_ch.pos_z         = out_pz_r;
  assign out_ch.tex_u         = out_tu_r;
  assign out_ch.tex_v         = out_tv_r;
  assign out_ch.vertex_number = out_vn_r;
  assign out_ch.corner_a      = out_ca_r;
  assign out_ch.corner_b      = out_cb_r;
  assign out_ch.corner_c      = out_cc_r;
  assign out_ch.last          = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (qstat.valid) begin
            seg_r   <= head;
            state_r <= S_ABS;
          end
        end
        S_ABS: begin
          // b - a of two signed words needs 33 bits, held here in 34
          logic signed [33:0] d [3];
          d[0] = {{2{seg_r.bx[31]}}, seg_r.bx} - {{2{seg_r.ax[31]}}, seg_r.ax};
          d[1] = {{2{seg_r.by[31]}}, seg_r.by} - {{2{seg_r.ay[31]}}, seg_r.ay};
          d[2] = {{2{seg_r.bz[31]}}, seg_r.bz} - {{2{seg_r.az[31]}}, seg_r.az};
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= d[i][33];
            m_r[i]   <= d[i][33] ? 33'(-d[i]) : 33'(d[i]);
          end
          state_r <= S_MAX;
        end
        S_MAX: begin
          logic [32:0] t;
          t = (m_r[0] > m_r[1]) ? m_r[0] : m_r[1];
          t = (m_r[2] > t) ? m_r[2] : t;
          mx_r <= t;
          if (t == '0) begin
            for (int i = 0; i < 3; i++) e_r[i] <= '0;
            k_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // one bit of shift a cycle until the largest lies in [2^29, 2^30)
          if (mx_r[32:30] != '0) begin
            mx_r <= mx_r >> 1;
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else if (!mx_r[29]) begin
            mx_r <= mx_r << 1;
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            sum_r   <= '0;
            idx_r   <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sum_r <= sum_r + m_r[idx_r][29:0] * m_r[idx_r][29:0];
          if (idx_r == 2'd2) begin
            state_r <= S_ROOT;
            res_r   <= '0;
            bit_r   <= 64'd1 << 62;
            v_r     <= '0;
          end else begin
            idx_r <= idx_r + 2'd1;
          end
        end
        S_ROOT: begin
          if (bit_r == '0) begin
            len_r   <= res_r[31:0];
            idx_r   <= '0;
            state_r <= S_MUL;
          end else begin
            logic [63:0] vv;
            vv = (bit_r == (64'd1 << 62) && v_r == '0 && res_r == '0) ?
                 {2'b0, sum_r} : v_r;
            if (vv >= res_r + bit_r) begin
              v_r   <= vv - rb;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              v_r   <= vv;
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        S_MUL: begin
          prod_r  <= m_r[idx_r][29:0] * half_width;
          state_r <= S_DIV0;
        end
        S_DIV0: begin
          rem_r   <= num[63:32];
          lo_r    <= num[31:0];
          quo_r   <= '0;
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (step_r == 6'd32) begin
            e_r[idx_r] <= neg_r[idx_r] ? 32'd0 - quo_r : quo_r;
            if (idx_r == 2'd2) begin
              k_r     <= '0;
              state_r <= S_EMIT;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_MUL;
            end
          end else begin
            if (trial >= {1'b0, len_r}) begin
              rem_r <= 32'(trial - {1'b0, len_r});
              quo_r <= {quo_r[30:0], 1'b1};
            end else begin
              rem_r <= trial[31:0];
              quo_r <= {quo_r[30:0], 1'b0};
            end
            lo_r   <= lo_r << 1;
            step_r <= step_r + 6'd1;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_last_r  <= (k_r == 4'd13);
            if (!k_r[3]) begin
              out_kind_r <= KIND_VERTEX;
              out_px_r   <= bpx + ox;
              out_py_r   <= bpy + oy;
              out_pz_r   <= bpz + oz;
              out_tu_r   <= tex_u_of(tk);
              out_tv_r   <= tex_v_of(tk);
              out_vn_r   <= seg_r.base + {13'b0, tk};
              out_ca_r   <= '0;
              out_cb_r   <= '0;
              out_cc_r   <= '0;
            end else begin
              out_kind_r <= KIND_TRIANGLE;
              out_px_r   <= '0;
              out_py_r   <= '0;
              out_pz_r   <= '0;
              out_tu_r   <= '0;
              out_tv_r   <= '0;
              out_vn_r   <= '0;
              out_ca_r   <= seg_r.base + {13'b0, tri_corner(tk, 2'd0)};
              out_cb_r   <= seg_r.base + {13'b0, tri_corner(tk, 2'd1)};
              out_cc_r   <= seg_r.base + {13'b0, tri_corner(tk, 2'd2)};
            end
            if (k_r == 4'd13) begin
              state_r <= S_IDLE;
            end else begin
              k_r <= k_r + 4'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/polyline_segment_extruder.sv @@
// top level: config register, front, segment queue and back
// a segment's first record follows its point through the front, the queue and the back:
// normalize shifts, three squares, a bit-by-bit root and three divides on one shared
// divider, then one record a cycle while the receiver is ready (zero length skips to records)
// throughput is set by the back, which takes the next segment only after its last record
// is registered; path start and first points queue no segment and give no record
// rst_n is synchronous: clears previous point, vertex base, queue and sets half_width to 1.0
`timescale 1ns / 1ps
`default_nettype none
module polyline_segment_extruder
  import pse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  pse_in_if.sink           in_ch,
  pse_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam logic REG_HALF_WIDTH = 1'b0;

  logic [30:0] hw_r, hw_nxt;
  pse_push_t   push;
  pse_qstat_t  qstat;
  pse_seg_t    head;
  logic        pop;
  logic        wr_beat;

  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite && pready;
  assign prdata  = (paddr[2] == REG_HALF_WIDTH) ? {1'b0, hw_r} : 32'd0;

  always_comb begin
    hw_nxt = hw_r;
    if (wr_beat && paddr[2] == REG_HALF_WIDTH) begin
      hw_nxt = pwdata[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= 31'd65536;
    end else begin
      hw_r <= hw_nxt;
    end
  end

  pse_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .qstat (qstat),
    .push  (push)
  );

  pse_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .qstat (qstat),
    .head  (head)
  );

  pse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .head       (head),
    .half_width (hw_r),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !qstat.full)
    else $error("segment pushed into a full queue");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> qstat.valid)
    else $error("pop from an empty queue");

  a_last_is_tri: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last |-> out_ch.kind == KIND_TRIANGLE)
    else $error("last beat is not a triangle record");

  a_start_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.path_start |-> !push.valid)
    else $error("path start point queued a segment");

endmodule
`default_nettype wire

@@ tb/tb_polyline_segment_extruder.sv @@
// self-checking testbench for the polyline segment extruder
`timescale 1ns / 1ps
`default_nettype none
module tb_polyline_segment_extruder;
  import pse_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        start;
  } point_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] u;
    logic [15:0] v;
    logic [15:0] vnum;
    logic [15:0] ca;
    logic [15:0] cb;
    logic [15:0] cc;
    logic        last;
  } record_t;

  localparam logic [2:0] ADDR_HALF_WIDTH = 3'd0;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pse_in_if in_ch();
  pse_out_if out_ch();

  polyline_segment_extruder dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [30:0] hw_q = 31'd65536;
  logic [31:0] last_x = '0, last_y = '0, last_z = '0;
  logic        have_last = 1'b0;
  logic [15:0] base_q = '0;

  point_t  pending_pts[$];
  record_t expected_recs[$];
  int errors = 0, segs_done = 0, recs_seen = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit send_en = 1'b0;

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] u_of(input int k);
    if (k < 2) return TEX_LO;
    if (k > 5) return TEX_HI;
    return TEX_MID;
  endfunction

  // add the fourteen records of segment last point -> p
  task automatic extrude(input point_t p);
    logic signed [63:0] d[3];
    logic [63:0] m[3], mx, sum, len, q;
    logic [31:0] e[3], ex, ey, ez, ox, oy, oz, bxx, byy, bzz;
    logic [2:0] tri_c[6][3];
    record_t r;
    int i;
    tri_c = '{'{0,2,1}, '{2,3,1}, '{2,4,3}, '{4,5,3}, '{4,6,5}, '{6,7,5}};
    d[0] = $signed(p.x) - $signed(last_x);
    d[1] = $signed(p.y) - $signed(last_y);
    d[2] = $signed(p.z) - $signed(last_z);
    mx = 0;
    for (i = 0; i < 3; i++) begin
      m[i] = d[i] < 0 ? -d[i] : d[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      e = '{0, 0, 0};
    end else begin
      while (mx >= (64'd1 << 30)) begin
        mx = mx >> 1;
        for (i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx = mx << 1;
        for (i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      sum = 0;
      for (i = 0; i < 3; i++) sum += m[i] * m[i];
      len = root64(sum);
      for (i = 0; i < 3; i++) begin
        q = (m[i] * {33'd0, hw_q} + (len >> 1)) / len;
        e[i] = d[i] < 0 ? -q[31:0] : q[31:0];
      end
    end
    ex = e[0]; ey = e[1]; ez = e[2];
    for (i = 0; i < 8; i++) begin
      case (i)
        0: begin ox = ey - ex; oy = -ex - ey; oz = -ez; end
        1: begin ox = -ey - ex; oy = ex - ey; oz = -ez; end
        2, 4: begin ox = ey; oy = -ex; oz = 0; end
        3, 5: begin ox = -ey; oy = ex; oz = 0; end
        6: begin ox = ey + ex; oy = ey - ex; oz = ez; end
        default: begin ox = ex - ey; oy = ex + ey; oz = ez; end
      endcase
      bxx = i < 4 ? last_x : p.x;
      byy = i < 4 ? last_y : p.y;
      bzz = i < 4 ? last_z : p.z;
      r = '0;
      r.kind = KIND_VERTEX;
      r.px = bxx + ox; r.py = byy + oy; r.pz = bzz + oz;
      r.u = u_of(i);
      r.v = i[0] ? TEX_HI : TEX_LO;
      r.vnum = base_q + 16'(i);
      expected_recs = {expected_recs, r};
    end
    for (i = 0; i < 6; i++) begin
      r = '0;
      r.kind = KIND_TRIANGLE;
      r.ca = base_q + tri_c[i][0];
      r.cb = base_q + tri_c[i][1];
      r.cc = base_q + tri_c[i][2];
      r.last = (i == 5);
      expected_recs = {expected_recs, r};
    end
    base_q = base_q + BASE_STEP;
  endtask

  task automatic take_point(input point_t p);
    if (p.start || !have_last) begin
      if (p.start) base_q = '0;
      have_last = 1'b1;
    end else begin
      extrude(p);
      segs_done++;
    end
    last_x = p.x; last_y = p.y; last_z = p.z;
  endtask

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.point_x = '0; in_ch.point_y = '0; in_ch.point_z = '0;
    in_ch.path_start = 1'b0;
  end
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        take_point(pending_pts.pop_front());
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (send_en && pending_pts.size() > 0) begin
          in_ch.valid <= 1'b1;
          {in_ch.point_x, in_ch.point_y, in_ch.point_z, in_ch.path_start} <= pending_pts[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 6);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker; receiver stall pattern and long hold count
  int stall_phase = 0;
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    record_t got, exp_r;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.kind, out_ch.pos_x, out_ch.pos_y, out_ch.pos_z, out_ch.tex_u,
               out_ch.tex_v, out_ch.vertex_number, out_ch.corner_a, out_ch.corner_b,
               out_ch.corner_c, out_ch.last};
        recs_seen++;
        if (expected_recs.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, actual %h", $time, got);
        end else begin
          exp_r = expected_recs.pop_front();
          if (got !== exp_r) begin
            errors++;
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
          end
        end
      end
      if (hold_left > 0) hold_left--;
      stall_phase = (stall_phase + 1) % 23;
      out_ch.ready <= (hold_left == 0) && (stall_phase < 12 || stall_phase[0]);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !send_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d records pending", expected_recs.size());
      $display("[polyline_segment_extruder] ERROR");
      $finish;
    end
  end

  task automatic cfg_write(input logic [30:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_HALF_WIDTH; pwdata <= {1'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    hw_q = val;
  endtask

  task automatic add_pt(input logic [31:0] x, y, z, input logic s);
    point_t p;
    p.x = x; p.y = y; p.z = z; p.start = s;
    pending_pts = {pending_pts, p};
  endtask

  task automatic drain;
    send_en = 1'b1;
    while (pending_pts.size() > 0 || expected_recs.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    send_en = 1'b0;
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 2000) - 1000;
      2: return {{14{1'b0}}, 18'($urandom)} - 32'h0002_0000;
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [31:0] last_pt_x();
    return pending_pts.size() ? pending_pts[$].x : 32'd0;
  endfunction

  task automatic random_paths(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_pt(rnd_coord(), rnd_coord(), rnd_coord(), 1'b1);
      else if ($urandom_range(0, 7) == 0)
        add_pt(last_pt_x(), rnd_coord(), rnd_coord(), 1'b0);
      else
        add_pt(rnd_coord(), rnd_coord(), rnd_coord(), 1'b0);
    end
  endtask

  int k;
  logic [30:0] widths[4];
  initial begin
    widths = '{31'd0, 31'h7fff_ffff, 31'd1, 31'd200000};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: first point without start, degenerate, extremes, wraps
    add_pt(32'h0001_0000, 0, 0, 1'b0);
    add_pt(32'h0003_0000, 0, 0, 1'b0);
    add_pt(32'h0003_0000, 0, 0, 1'b0);
    add_pt(32'h0003_0000, 32'h0005_0000, 32'hffff_0000, 1'b0);
    add_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    add_pt(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    add_pt(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    add_pt(32'h8000_0001, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    add_pt(0, 0, 1, 1'b0);
    add_pt(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_pt(0, 0, 0, 1'b1);
    add_pt(32'hdead_beef, 32'h1234_5678, 32'h0f0f_0f0f, 1'b0);
    drain();

    // long receiver hold so the input backs up
    random_paths(12);
    hold_left = 3000;
    send_en = 1'b1;
    while (hold_left > 0) @(posedge clk);
    drain();

    // each width, including both extremes
    for (k = 0; k < 4; k++) begin
      cfg_write(widths[k]);
      random_paths(70);
      drain();
    end
    cfg_write(31'($urandom));
    random_paths(40);
    drain();

    // one path of short steps along x
    cfg_write(31'd65536);
    add_pt(0, 0, 0, 1'b1);
    for (k = 0; k < 15; k++) add_pt(32'($urandom_range(0, 9)) << 16, 0, 0, 1'b0);
    drain();

    $display("covered %0d segments, %0d records checked, widths incl. 0 and max",
             segs_done, recs_seen);
    if (errors == 0 && expected_recs.size() == 0) begin
      $display("[polyline_segment_extruder] OK");
    end else begin
      $display("[polyline_segment_extruder] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
design/pse_pkg.sv
design/pse_if.sv
design/pse_front.sv
design/pse_queue.sv
design/pse_back.sv
design/polyline_segment_extruder.sv
tb/tb_polyline_segment_extruder.sv
